/* rtl/u2a_pkg.sv */
// shared types, constants and code point mapping for the utf-8 to ascii transliterator
// no dependencies; used by u2a_decode, u2a_outbuf and utf8_to_ascii_transliterator

package u2a_pkg;

    // one result beat
    typedef struct packed {
        logic [6:0] char_byte;
        logic       has_char;
        logic       string_end;
        logic       run_last;
    } res_t;

    // ascii characters produced by the mapping
    localparam logic [6:0] CH_NONE     = 7'h00;
    localparam logic [6:0] CH_QUESTION = 7'h3F;
    localparam logic [6:0] CH_QUOTE    = 7'h22;
    localparam logic [6:0] CH_APOS     = 7'h27;
    localparam logic [6:0] CH_DOT      = 7'h2E;
    localparam logic [6:0] CH_DASH     = 7'h2D;
    localparam logic [6:0] CH_STAR     = 7'h2A;
    localparam logic [6:0] CASE_OFFSET = 7'h20;

    // latin-1 letters U+00C0..U+00DF, zero where the letter maps to a question mark
    localparam logic [6:0] LATIN_UPPER [32] = '{
        7'h41, 7'h41, 7'h41, 7'h41, 7'h41, 7'h41, 7'h41, 7'h43,
        7'h45, 7'h45, 7'h45, 7'h45, 7'h49, 7'h49, 7'h49, 7'h49,
        7'h00, 7'h4E, 7'h4F, 7'h4F, 7'h4F, 7'h4F, 7'h4F, 7'h00,
        7'h4F, 7'h55, 7'h55, 7'h55, 7'h55, 7'h00, 7'h00, 7'h00
    };

    // continuation byte 10xxxxxx
    function automatic logic is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    // two-byte lead 110xxxxx
    function automatic logic is_lead2(input logic [7:0] b);
        return b[7:5] == 3'b110;
    endfunction

    // three-byte lead 1110xxxx
    function automatic logic is_lead3(input logic [7:0] b);
        return b[7:4] == 4'b1110;
    endfunction

    // ascii byte as a character, zero for nul and for any non-ascii byte
    function automatic logic [6:0] ascii_of(input logic [7:0] b);
        return b[7] ? CH_NONE : b[6:0];
    endfunction

    // code point to ascii, zero when the code point is dropped
    function automatic logic [6:0] translit(input logic [15:0] cp);
        logic [6:0] up;
        logic [6:0] r;
        up = LATIN_UPPER[cp[4:0]];
        r  = CH_NONE;
        if (cp[15:8] == 8'h00 && cp[7])
        begin
            if (cp[6])
            begin
                if (up == CH_NONE)
                    r = CH_QUESTION;
                else if (cp[5])
                    r = up + CASE_OFFSET;
                else
                    r = up;
            end
            else if (cp[7:0] == 8'hAB || cp[7:0] == 8'hBB)
                r = CH_QUOTE;
            else if (cp[7:0] == 8'hB7)
                r = CH_DOT;
            else
                r = CH_QUESTION;
        end
        else if (cp inside {[16'h2000:16'h206F]})
        begin
            if (cp inside {[16'h2010:16'h2015]})
                r = CH_DASH;
            else if (cp inside {[16'h2018:16'h201A], 16'h2032})
                r = CH_APOS;
            else if (cp inside {[16'h201C:16'h201E], 16'h2033})
                r = CH_QUOTE;
            else if (cp == 16'h2026)
                r = CH_DOT;
            else if (cp inside {16'h2022, 16'h2023})
                r = CH_STAR;
            else
                r = CH_NONE;
        end
        return r;
    endfunction

endpackage

/* rtl/u2a_decode.sv */
// sequence state and single-pass decode of one byte into up to two result beats
// depends on u2a_pkg

module u2a_decode (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       data_byte,
    input  logic             is_final,
    output u2a_pkg::res_t    res0,
    output u2a_pkg::res_t    res1,
    output logic [1:0]       res_cnt
);

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_TWO   = 2'd1;
    localparam logic [1:0] KIND_THREE = 2'd2;
    localparam logic [1:0] KIND_FOUR  = 2'd3;

    logic [1:0] kind_reg,     kind_next;
    logic [1:0] held_cnt_reg, held_cnt_next;
    logic [7:0] lead_reg,     lead_next;
    logic [7:0] held0_reg,    held0_next;
    logic [7:0] held1_reg,    held1_next;

    logic       do_fresh;
    logic [6:0] step_ch;
    logic [6:0] r0;
    logic [6:0] r1;
    logic [6:0] c0;
    logic [6:0] c1;
    logic [1:0] n_chars;

    // byte against the open sequence
    always_comb
    begin
        kind_next     = kind_reg;
        held_cnt_next = held_cnt_reg;
        lead_next     = lead_reg;
        held0_next    = held0_reg;
        held1_next    = held1_reg;
        step_ch       = u2a_pkg::CH_NONE;
        do_fresh      = 1'b0;
        case (kind_reg)
            KIND_NONE:
                do_fresh = 1'b1;
            KIND_FOUR:
            begin
                if (held_cnt_reg == 2'd0)
                begin
                    held0_next    = data_byte;
                    held_cnt_next = 2'd1;
                end
                else if (held_cnt_reg == 2'd1)
                begin
                    held1_next    = data_byte;
                    held_cnt_next = 2'd2;
                end
                else
                begin
                    kind_next     = KIND_NONE;
                    held_cnt_next = 2'd0;
                end
            end
            KIND_TWO:
            begin
                if (u2a_pkg::is_cont(data_byte))
                begin
                    step_ch = u2a_pkg::translit({5'b0, lead_reg[4:0], data_byte[5:0]});
                    kind_next     = KIND_NONE;
                    held_cnt_next = 2'd0;
                end
                else
                    do_fresh = 1'b1;
            end
            KIND_THREE:
            begin
                if (u2a_pkg::is_cont(data_byte))
                begin
                    if (held_cnt_reg == 2'd0)
                    begin
                        held0_next    = data_byte;
                        held_cnt_next = 2'd1;
                    end
                    else
                    begin
                        step_ch = u2a_pkg::translit({lead_reg[3:0], held0_reg[5:0],
                                                     data_byte[5:0]});
                        kind_next     = KIND_NONE;
                        held_cnt_next = 2'd0;
                    end
                end
                else
                    do_fresh = 1'b1;
            end
            default:
                do_fresh = 1'b1;
        endcase

        // fresh byte with no sequence open; a broken lead and its held
        // continuation bytes are dropped here
        if (do_fresh)
        begin
            kind_next     = KIND_NONE;
            held_cnt_next = 2'd0;
            if (!data_byte[7])
                step_ch = data_byte[6:0];
            else if (u2a_pkg::is_lead2(data_byte))
            begin
                kind_next = KIND_TWO;
                lead_next = data_byte;
            end
            else if (u2a_pkg::is_lead3(data_byte))
            begin
                kind_next = KIND_THREE;
                lead_next = data_byte;
            end
            else if (data_byte[7:3] == 5'b11110)
            begin
                kind_next = KIND_FOUR;
                lead_next = data_byte;
            end
        end
    end

    // string end: bytes held under a four-byte lead are decoded afresh
    always_comb
    begin
        r0 = u2a_pkg::CH_NONE;
        r1 = u2a_pkg::CH_NONE;
        if (is_final && kind_next == KIND_FOUR)
        begin
            if (held_cnt_next == 2'd1)
                r0 = u2a_pkg::ascii_of(held0_next);
            else if (held_cnt_next == 2'd2)
            begin
                if (u2a_pkg::is_lead2(held0_next) && u2a_pkg::is_cont(held1_next))
                    r0 = u2a_pkg::translit({5'b0, held0_next[4:0], held1_next[5:0]});
                else
                    r0 = u2a_pkg::ascii_of(held0_next);
                if ((u2a_pkg::is_lead2(held0_next) || u2a_pkg::is_lead3(held0_next))
                    && u2a_pkg::is_cont(held1_next))
                    r1 = u2a_pkg::CH_NONE;
                else
                    r1 = u2a_pkg::ascii_of(held1_next);
            end
        end
    end

    // pack characters into result beats; the step character and the
    // end-of-string replay never occur together
    always_comb
    begin
        if (step_ch != u2a_pkg::CH_NONE)
            c0 = step_ch;
        else if (r0 != u2a_pkg::CH_NONE)
            c0 = r0;
        else
            c0 = r1;
        c1 = (r0 != u2a_pkg::CH_NONE && r1 != u2a_pkg::CH_NONE) ? r1 : u2a_pkg::CH_NONE;
        n_chars = {1'b0, c0 != u2a_pkg::CH_NONE} + {1'b0, c1 != u2a_pkg::CH_NONE};

        res1.char_byte  = c1;
        res1.has_char   = 1'b1;
        res1.string_end = is_final;
        res1.run_last   = 1'b1;
        if (n_chars == 2'd0)
        begin
            res0.char_byte  = u2a_pkg::CH_NONE;
            res0.has_char   = 1'b0;
            res0.string_end = 1'b1;
            res0.run_last   = 1'b1;
            res_cnt         = is_final ? 2'd1 : 2'd0;
        end
        else
        begin
            res0.char_byte  = c0;
            res0.has_char   = 1'b1;
            res0.string_end = is_final && n_chars == 2'd1;
            res0.run_last   = n_chars == 2'd1;
            res_cnt         = n_chars;
        end
    end

    // sequence control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg     <= KIND_NONE;
            held_cnt_reg <= 2'd0;
        end
        else if (step)
        begin
            kind_reg     <= is_final ? KIND_NONE : kind_next;
            held_cnt_reg <= is_final ? 2'd0 : held_cnt_next;
        end
    end

    // held bytes, read only while a lead is open
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            lead_reg  <= lead_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

endmodule

/* rtl/u2a_outbuf.sv */
// two-entry result register that drains one beat per cycle while out_ready is high
// depends on u2a_pkg

module u2a_outbuf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  u2a_pkg::res_t    res0,
    input  u2a_pkg::res_t    res1,
    input  logic [1:0]       res_cnt,
    input  logic             out_ready,
    output logic             out_valid,
    output u2a_pkg::res_t    head,
    output logic             free
);

    logic [1:0]    cnt_reg, cnt_next;
    u2a_pkg::res_t s0_reg,  s0_next;
    u2a_pkg::res_t s1_reg,  s1_next;
    logic          pop;

    assign out_valid = cnt_reg != 2'd0;
    assign head      = s0_reg;
    assign pop       = out_valid && out_ready;
    assign free      = cnt_reg == 2'd0 || (cnt_reg == 2'd1 && out_ready);

    // drain head, then take a new group of beats
    always_comb
    begin
        cnt_next = cnt_reg;
        s0_next  = s0_reg;
        s1_next  = s1_reg;
        if (pop)
        begin
            s0_next  = s1_reg;
            cnt_next = cnt_reg - 2'd1;
        end
        if (load)
        begin
            s0_next  = res0;
            s1_next  = res1;
            cnt_next = res_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        s0_reg <= s0_next;
        s1_reg <= s1_next;
    end

endmodule

/* rtl/utf8_to_ascii_transliterator.sv */
// Takes UTF-8 text one byte per beat, with is_final on the last byte of a string,
// and gives ASCII characters: one byte per cycle enters an input register while
// its results fit in the result register, is decoded against the open sequence in
// one pass and lands in a two-entry result register, from which the first result
// beat is offered. Most bytes give zero or one result beat and keep the
// one-byte-per-cycle rate; a final byte that ends a cut-off four-byte sequence
// can give two beats, which the result register hands out one after the other.
// A final byte with no character yields one bare end mark
// (has_char low, string_end high). Depends on u2a_pkg, u2a_decode, u2a_outbuf.

module utf8_to_ascii_transliterator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       is_final,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] char_byte,
    output logic       has_char,
    output logic       string_end,
    output logic       run_last
);

    logic          a_valid_reg, a_valid_next;
    logic [7:0]    a_byte_reg;
    logic          a_final_reg;
    logic          a_adv;
    logic          buf_free;
    logic          in_beat;
    u2a_pkg::res_t res0;
    u2a_pkg::res_t res1;
    u2a_pkg::res_t head;
    logic [1:0]    res_cnt;

    // input register moves on when its results fit or there are none
    assign a_adv    = a_valid_reg && (res_cnt == 2'd0 || buf_free);
    assign in_ready = !a_valid_reg || a_adv;
    assign in_beat  = in_valid && in_ready;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (in_beat)
            a_valid_next = 1'b1;
        else if (a_adv)
            a_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= a_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            a_byte_reg  <= data_byte;
            a_final_reg <= is_final;
        end
    end

    // decode
    u2a_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (a_adv),
        .data_byte (a_byte_reg),
        .is_final  (a_final_reg),
        .res0      (res0),
        .res1      (res1),
        .res_cnt   (res_cnt)
    );

    // result register
    u2a_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (a_adv && res_cnt != 2'd0),
        .res0      (res0),
        .res1      (res1),
        .res_cnt   (res_cnt),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .head      (head),
        .free      (buf_free)
    );

    assign char_byte  = head.char_byte;
    assign has_char   = head.has_char;
    assign string_end = head.string_end;
    assign run_last   = head.run_last;

`ifndef NO_ASSERTIONS
    // the closing beat of a string is always the last beat of its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && string_end) |-> run_last)
        else $error("string end beat not marked as last of its byte");

    // a beat without a character is a bare end mark
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_char) |-> (string_end && char_byte == 7'd0))
        else $error("empty beat that is not an end mark");

    // with the result register empty the input side never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result pending");
`endif

endmodule
